@@ sv/nibble_packet_script_builder_unit_macros.svh @@
// Assertion macros used by the port-level checker of the nibble packet script builder.
`ifndef NIBBLE_PACKET_SCRIPT_BUILDER_UNIT_MACROS_SVH
`define NIBBLE_PACKET_SCRIPT_BUILDER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPSB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("npsb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NPSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("npsb assertion failed");

`endif

@@ sv/npsb_pkg.sv @@
// Package with the beat types and codes of the nibble packet script builder.
package npsb_pkg;

    localparam logic [1:0] FUNC_RESTART = 2'd0;
    localparam logic [1:0] FUNC_CHAR    = 2'd1;
    localparam logic [1:0] FUNC_EVENT   = 2'd2;

    localparam logic [1:0] RX_WORD    = 2'd0;
    localparam logic [1:0] RX_NOTHING = 2'd1;

    localparam logic [2:0] KIND_PENDING = 3'd0;
    localparam logic [2:0] KIND_WORD    = 3'd1;
    localparam logic [2:0] KIND_END     = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_EVENT   = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_CHECK = 8'h40;
    localparam logic [7:0] CH_INV   = 8'h5E;

    localparam logic [2:0] PHASE_DASH = 3'd0;
    localparam logic [2:0] PHASE_LAST = 3'd4;

    localparam logic [1:0] SLOT_TOP = 2'd3;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_INVERT,
        PFX_CHECK
    } prefix_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  ch;
        logic [1:0]  rx_status;
        logic [15:0] rx_data;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] word;
        logic [5:0]  logged_count;
    } out_beat_t;

endpackage

@@ sv/nibble_packet_script_builder_unit.sv @@
// Top level of the nibble packet script builder: parser, word builder and result register.
//
// Script characters, receive events and restarts arrive one beat each on the s_ channel; every
// beat gives exactly one result beat on the m_ channel, in the cycle after it is accepted. A new
// beat is taken in every cycle as long as the result register is empty or being drained, so
// the sustained rate is one beat per clock. That figure is set by the parser state, which is
// updated by one pass of nibble-mask and 4-bit add logic per beat, and by the single output
// register, which s_ready follows through m_ready. The log holds no data here: only its fill
// count, capped at LOG_DEPTH, and the last logged word are kept.
module nibble_packet_script_builder_unit
    import npsb_pkg::*;
#(
    parameter int LOG_DEPTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int CntW = $clog2(LOG_DEPTH + 1);

    logic [15:0]     last_word_reg, last_word_next;
    logic [3:0]      sum_reg, sum_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [2:0]      phase_reg, phase_next;
    prefix_t         prefix_reg, prefix_next;
    logic [15:0]     partial_reg, partial_next;
    logic [15:0]     copy_reg, copy_next;
    logic [15:0]     invert_reg, invert_next;
    logic            target_on_reg, target_on_next;
    logic [3:0]      target_reg, target_next;
    logic [1:0]      slot_reg, slot_next;
    logic            done_reg, done_next;
    logic            error_reg, error_next;
    logic            out_valid_reg, out_valid_next;
    out_beat_t       out_data_reg, out_data_next;

    logic            accept;
    logic [4:0]      hex;
    logic [1:0]      pos;
    logic [15:0]     digit_shifted;
    logic [15:0]     built;
    logic [3:0]      nib_sum;
    logic            log_req;
    logic [15:0]     log_val;
    logic [2:0]      kind;
    logic [15:0]     word;
    logic [CntW+5:0] count_ext;

    // Returns the digit value in the low bits, with the top bit set for a non-hex character.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign hex           = hex_of(s_data.ch);
    assign pos           = 2'(PHASE_LAST - phase_reg);
    assign digit_shifted = 16'(hex[3:0]) << {pos, 2'b00};

    always_comb begin
        last_word_next = last_word_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        prefix_next    = prefix_reg;
        partial_next   = partial_reg;
        copy_next      = copy_reg;
        invert_next    = invert_reg;
        target_on_next = target_on_reg;
        target_next    = target_reg;
        slot_next      = slot_reg;
        done_next      = done_reg;
        error_next     = error_reg;
        kind           = KIND_PENDING;
        word           = 16'd0;
        log_req        = 1'b0;
        log_val        = 16'd0;
        built          = 16'd0;
        nib_sum        = 4'd0;

        unique case (s_data.func)
            FUNC_RESTART: begin
                last_word_next = 16'd0;
                sum_next       = 4'd0;
                count_next     = '0;
                done_next      = 1'b0;
                error_next     = 1'b0;
                phase_next     = PHASE_DASH;
                prefix_next    = PFX_NONE;
                partial_next   = 16'd0;
                copy_next      = 16'd0;
                invert_next    = 16'd0;
                target_on_next = 1'b0;
                target_next    = 4'd0;
                slot_next      = SLOT_TOP;
            end
            FUNC_EVENT: begin
                kind = KIND_EVENT;
                if (s_data.rx_status == RX_WORD) begin
                    log_req = 1'b1;
                    log_val = s_data.rx_data;
                end else if (s_data.rx_status == RX_NOTHING) begin
                    log_req = 1'b1;
                end
            end
            FUNC_CHAR: begin
                priority if (error_reg) begin
                    kind = KIND_ERROR;
                end else if (done_reg) begin
                    kind = KIND_END;
                end else if (phase_reg == PHASE_DASH) begin
                    if (s_data.ch == CH_NUL || s_data.ch == CH_SPACE) begin
                        done_next = 1'b1;
                        kind      = KIND_END;
                    end else if (s_data.ch == CH_DASH) begin
                        phase_next = 3'd1;
                    end else begin
                        error_next = 1'b1;
                        kind       = KIND_ERROR;
                    end
                end else if (prefix_reg == PFX_NONE
                             && (s_data.ch == CH_INV || s_data.ch == CH_CHECK)) begin
                    prefix_next = (s_data.ch == CH_INV) ? PFX_INVERT : PFX_CHECK;
                end else if (hex[4]) begin
                    error_next = 1'b1;
                    kind       = KIND_ERROR;
                end else begin
                    unique case (prefix_reg)
                        PFX_CHECK: begin
                            target_on_next = 1'b1;
                            target_next    = hex[3:0];
                            slot_next      = pos;
                        end
                        PFX_INVERT: begin
                            copy_next   = copy_reg | (~digit_shifted & (16'hF << {pos, 2'b00}));
                            invert_next = invert_reg | digit_shifted;
                        end
                        default: begin
                            partial_next = partial_reg | digit_shifted;
                        end
                    endcase
                    prefix_next = PFX_NONE;
                    if (phase_reg == PHASE_LAST) begin
                        built = (partial_next & ~copy_next) | (copy_next & last_word_reg);
                        built = (built & ~invert_next) | (invert_next & ~last_word_reg);
                        if (target_on_next) begin
                            built[{slot_next, 2'b00} +: 4] = 4'd0;
                        end
                        nib_sum = sum_reg + built[3:0] + built[7:4] + built[11:8]
                                  + built[15:12];
                        if (target_on_next) begin
                            built[{slot_next, 2'b00} +: 4] = target_next - nib_sum;
                            nib_sum = target_next;
                        end
                        sum_next       = nib_sum;
                        word           = built;
                        kind           = KIND_WORD;
                        log_req        = 1'b1;
                        log_val        = built;
                        phase_next     = PHASE_DASH;
                        partial_next   = 16'd0;
                        copy_next      = 16'd0;
                        invert_next    = 16'd0;
                        target_on_next = 1'b0;
                        target_next    = 4'd0;
                        slot_next      = SLOT_TOP;
                    end else begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (log_req && count_reg < CntW'(LOG_DEPTH)) begin
            count_next     = count_reg + 1'b1;
            last_word_next = log_val;
        end
    end

    assign count_ext = {6'd0, count_next};

    always_comb begin
        out_data_next.kind         = kind;
        out_data_next.word         = word;
        out_data_next.logged_count = count_ext[5:0];
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_word_reg <= 16'd0;
            sum_reg       <= 4'd0;
            count_reg     <= '0;
            phase_reg     <= PHASE_DASH;
            prefix_reg    <= PFX_NONE;
            partial_reg   <= 16'd0;
            copy_reg      <= 16'd0;
            invert_reg    <= 16'd0;
            target_on_reg <= 1'b0;
            target_reg    <= 4'd0;
            slot_reg      <= SLOT_TOP;
            done_reg      <= 1'b0;
            error_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                last_word_reg <= last_word_next;
                sum_reg       <= sum_next;
                count_reg     <= count_next;
                phase_reg     <= phase_next;
                prefix_reg    <= prefix_next;
                partial_reg   <= partial_next;
                copy_reg      <= copy_next;
                invert_reg    <= invert_next;
                target_on_reg <= target_on_next;
                target_reg    <= target_next;
                slot_reg      <= slot_next;
                done_reg      <= done_next;
                error_reg     <= error_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ sv/npsb_checker.sv @@
// Port-level checker for the nibble packet script builder and its bind statement.
`include "nibble_packet_script_builder_unit_macros.svh"

module npsb_checker
    import npsb_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // A result beat that is held back keeps its contents.
    `NPSB_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Every accepted beat shows up in the result register on the next cycle.
    `NPSB_ASSERT_NEXT(a_result, aclk, aresetn, s_valid && s_ready, m_valid)

    // A restart answers pending with an empty log.
    `NPSB_ASSERT_NEXT(a_restart, aclk, aresetn,
        s_valid && s_ready && s_data.func == FUNC_RESTART,
        m_data.kind == KIND_PENDING && m_data.logged_count == 6'd0 && m_data.word == 16'd0)

    // With the result register empty, the input side is always open.
    `NPSB_ASSERT_SAME(a_open, aclk, aresetn, !m_valid, s_ready)

endmodule

bind nibble_packet_script_builder_unit npsb_checker u_npsb_checker (.*);

@@ bench/nibble_packet_script_builder_unit_checker.sv @@
// Checker that predicts every result beat of the nibble packet script builder and compares it.
module nibble_packet_script_builder_unit_checker
    import npsb_pkg::*;
#(
    parameter int LOG_DEPTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        fails,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] prev_word;
    logic [3:0]  csum;
    int unsigned entries;
    logic [2:0]  phase;
    prefix_t     pfx;
    logic [15:0] lit_bits;
    logic [15:0] keep_mask;
    logic [15:0] flip_mask;
    logic        have_target;
    logic [3:0]  target;
    logic [1:0]  slot;
    logic        halted;
    logic        failed;

    out_beat_t awaited_results[$];
    out_beat_t want;
    int        mismatch_cnt = 0;

    function automatic void drop_segment();
        phase = PHASE_DASH;
        pfx = PFX_NONE;
        lit_bits = '0;
        keep_mask = '0;
        flip_mask = '0;
        have_target = 1'b0;
        target = '0;
        slot = SLOT_TOP;
    endfunction

    function automatic void restart_script();
        prev_word = '0;
        csum = '0;
        entries = 0;
        halted = 1'b0;
        failed = 1'b0;
        drop_segment();
    endfunction

    function automatic void log_word(input logic [15:0] w);
        if (entries < LOG_DEPTH) begin
            entries++;
            prev_word = w;
        end
    endfunction

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = '0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies the copy and invert masks, then, when a check target is set, fills the check nibble
    // so the running sum lands on the target.
    function automatic logic [15:0] assemble_word();
        logic [15:0] b;
        logic [3:0]  s;
        logic [3:0]  cd;
        logic [3:0]  sh;
        sh = {slot, 2'b00};
        b = lit_bits;
        b = (b & ~keep_mask) | (keep_mask & prev_word);
        b = (b & ~flip_mask) | (flip_mask & ~prev_word);
        if (have_target) begin
            b = b & ~(16'h000F << sh);
        end
        s = csum + b[3:0] + b[7:4] + b[11:8] + b[15:12];
        if (have_target) begin
            cd = target - s;
            b = b | ({12'd0, cd} << sh);
            s = target;
        end
        csum = s;
        return b;
    endfunction

    function automatic out_beat_t script_step(input in_beat_t b);
        out_beat_t   r;
        logic [3:0]  dv;
        logic [3:0]  sh;
        logic [1:0]  idx;
        logic [2:0]  back;
        bit          is_hex;
        r.kind = KIND_PENDING;
        r.word = '0;
        case (b.func)
            FUNC_RESTART: begin
                restart_script();
            end
            FUNC_EVENT: begin
                if (b.rx_status == RX_WORD) begin
                    log_word(b.rx_data);
                end else if (b.rx_status == RX_NOTHING) begin
                    log_word(16'h0000);
                end
                r.kind = KIND_EVENT;
            end
            FUNC_CHAR: begin
                is_hex = hex_digit(b.ch, dv);
                back = PHASE_LAST - phase;
                idx = back[1:0];
                sh = {idx, 2'b00};
                if (failed) begin
                    r.kind = KIND_ERROR;
                end else if (halted) begin
                    r.kind = KIND_END;
                end else if (phase == PHASE_DASH) begin
                    if (b.ch == CH_NUL || b.ch == CH_SPACE) begin
                        halted = 1'b1;
                        r.kind = KIND_END;
                    end else if (b.ch == CH_DASH) begin
                        phase = PHASE_DASH + 3'd1;
                    end else begin
                        failed = 1'b1;
                        r.kind = KIND_ERROR;
                    end
                end else if (pfx == PFX_NONE && (b.ch == CH_INV || b.ch == CH_CHECK)) begin
                    pfx = (b.ch == CH_INV) ? PFX_INVERT : PFX_CHECK;
                end else if (!is_hex) begin
                    failed = 1'b1;
                    r.kind = KIND_ERROR;
                end else begin
                    case (pfx)
                        PFX_CHECK: begin
                            have_target = 1'b1;
                            target = dv;
                            slot = idx;
                        end
                        PFX_INVERT: begin
                            keep_mask = keep_mask | ({12'd0, ~dv} << sh);
                            flip_mask = flip_mask | ({12'd0, dv} << sh);
                        end
                        default: begin
                            lit_bits = lit_bits | ({12'd0, dv} << sh);
                        end
                    endcase
                    pfx = PFX_NONE;
                    if (phase >= PHASE_LAST) begin
                        r.word = assemble_word();
                        log_word(r.word);
                        drop_segment();
                        r.kind = KIND_WORD;
                    end else begin
                        phase++;
                    end
                end
            end
            default: begin
            end
        endcase
        r.logged_count = entries[5:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
        $display("%0t ns: %s: expected %0h, got %0h", $time, what, exp_v, got_v);
        mismatch_cnt++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_script();
            awaited_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(script_step(s_data));
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("result beat with nothing awaited, kind", '0,
                                  16'(m_data.kind));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.kind !== want.kind) begin
                        flag_mismatch("kind", 16'(want.kind), 16'(m_data.kind));
                    end
                    if (m_data.word !== want.word) begin
                        flag_mismatch("word", want.word, m_data.word);
                    end
                    if (m_data.logged_count !== want.logged_count) begin
                        flag_mismatch("logged_count", 16'(want.logged_count),
                                      16'(m_data.logged_count));
                    end
                end
            end
        end
        fails <= mismatch_cnt;
        pending <= awaited_results.size();
    end

endmodule

@@ bench/tb_nibble_packet_script_builder_unit.sv @@
// Testbench top of the nibble packet script builder: clock, reset, stimulus and verdict.
module tb_nibble_packet_script_builder_unit
    import npsb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_DEPTH    = 32;
    localparam int ITEM_TARGET  = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [1:0] FUNC_IDLE = 2'd3;
    localparam logic [1:0] RX_ERROR  = 2'd2;
    localparam logic [1:0] RX_BAD    = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;
    logic      hold = 1'b0;

    int fails;
    int pending;
    int sent_cnt = 0;
    int recv_cnt = 0;
    int rx_wait = 0;
    int cycle_cnt = 0;

    always #2 aclk = ~aclk;

    nibble_packet_script_builder_unit #(
        .LOG_DEPTH(LOG_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    nibble_packet_script_builder_unit_checker #(
        .LOG_DEPTH(LOG_DEPTH)
    ) chk (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .fails  (fails),
        .pending(pending)
    );

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic in_beat_t noise_fields(input logic [1:0] f);
        in_beat_t b;
        b.func = f;
        b.ch = 8'($urandom);
        b.rx_status = 2'($urandom);
        b.rx_data = 16'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return "0" + v;
        end
        return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
    endfunction

    task automatic send_beat(input in_beat_t b);
        int g;
        g = pick_gap(((sent_cnt / 40) % 3) == 0);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
    endtask

    task automatic put_char(input logic [7:0] c);
        in_beat_t b;
        b = noise_fields(FUNC_CHAR);
        b.ch = c;
        send_beat(b);
    endtask

    task automatic put_event(input logic [1:0] st, input logic [15:0] d);
        in_beat_t b;
        b = noise_fields(FUNC_EVENT);
        b.rx_status = st;
        b.rx_data = d;
        send_beat(b);
    endtask

    task automatic put_position();
        case ($urandom_range(0, 3))
            2: put_char(CH_INV);
            3: put_char(CH_CHECK);
            default: begin
            end
        endcase
        put_char(hex_char(4'($urandom)));
    endtask

    task automatic put_segment();
        put_char(CH_DASH);
        repeat (4) put_position();
    endtask

    // A restart, a batch of well-formed segments mixed with receive events and idle beats, then some
    // kind of ending: a terminator, a broken segment, raw noise, or nothing at all.
    task automatic run_script();
        int nseg;
        send_beat(noise_fields(FUNC_RESTART));
        nseg = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        repeat (nseg) begin
            if (sent_cnt >= ITEM_TARGET) break;
            if ($urandom_range(0, 6) == 0) begin
                put_event(2'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 29) == 0) begin
                send_beat(noise_fields(FUNC_IDLE));
            end
            put_segment();
        end
        case ($urandom_range(0, 3))
            0: begin
                put_char($urandom_range(0, 1) ? CH_NUL : CH_SPACE);
                repeat ($urandom_range(0, 3)) put_char(8'($urandom));
            end
            1: begin
                put_char(CH_DASH);
                repeat ($urandom_range(0, 3)) put_position();
                if ($urandom_range(0, 1)) begin
                    put_char($urandom_range(0, 1) ? CH_INV : CH_CHECK);
                end
                put_char(8'($urandom));
                repeat ($urandom_range(0, 2)) put_char(8'($urandom));
            end
            2: begin
                repeat ($urandom_range(1, 4)) put_char(8'($urandom));
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                recv_cnt++;
                rx_wait = pick_gap(((recv_cnt / 40) % 3) == 1);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_ready <= !hold && rx_wait == 0;
        end
    end

    initial begin
        wait (sent_cnt >= HOLD_AFTER);
        @(posedge aclk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold <= 1'b0;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("nibble_packet_script_builder_unit: mismatch");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(noise_fields(FUNC_RESTART));
        put_char(CH_DASH);
        put_char("0");
        put_char("F");
        put_char("a");
        put_char("9");
        put_event(RX_WORD, 16'hFFFF);
        put_event(RX_NOTHING, 16'hFFFF);
        put_event(RX_ERROR, 16'h0000);
        put_event(RX_BAD, 16'h5A5A);
        send_beat(noise_fields(FUNC_IDLE));
        put_char(CH_DASH);
        put_char(CH_INV);
        put_char("5");
        put_char(CH_CHECK);
        put_char("f");
        put_char(CH_CHECK);
        put_char("3");
        put_char(CH_INV);
        put_char("A");
        put_char(CH_SPACE);
        put_char("Q");
        send_beat(noise_fields(FUNC_RESTART));
        put_char(CH_DASH);
        put_char(CH_INV);
        put_char(CH_CHECK);
        put_char(CH_DASH);
        send_beat(noise_fields(FUNC_RESTART));
        put_char(CH_NUL);

        while (sent_cnt < ITEM_TARGET) run_script();
        s_valid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("nibble_packet_script_builder_unit: match");
        end else begin
            $display("nibble_packet_script_builder_unit: mismatch");
        end
        $finish;
    end

endmodule
